FILE: design/ratc_pkg.sv
// Shared types and constants for the reverse address TTL cache.
package ratc_pkg;

   localparam int KEY_W    = 128;
   localparam int HALF_W   = 64;
   localparam int HANDLE_W = 32;
   localparam int TIME_W   = 32;
   localparam int EXPIRY_W = TIME_W + 1;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int INUSE_W  = 6;

   localparam logic [TIME_W-1:0] TTL_RESET = 32'd60;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAN  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_REFRESHED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_HIT        = 3'd3;
   localparam logic [STATUS_W-1:0] ST_MISS       = 3'd4;
   localparam logic [STATUS_W-1:0] ST_CLEANED    = 3'd5;
   localparam logic [STATUS_W-1:0] ST_CLEAN_SKIP = 3'd6;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_DRAIN,
      SEQ_WRITE,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      logic entry_we;
      logic expiry_we;
   } store_wr_type;

endpackage

FILE: design/ratc_if.sv
// Channel interfaces: request, response and TTL register write.
interface ratc_req_if;
   import ratc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      command;
   logic [HALF_W-1:0]     addr_high;
   logic [HALF_W-1:0]     addr_low;
   logic [HANDLE_W-1:0]   name_handle;
   logic [TIME_W-1:0]     now_seconds;
   modport source (output valid, command, addr_high, addr_low, name_handle, now_seconds,
                   input ready);
   modport sink   (input valid, command, addr_high, addr_low, name_handle, now_seconds,
                   output ready);
endinterface

interface ratc_rsp_if;
   import ratc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [HANDLE_W-1:0]   found_handle;
   logic [INUSE_W-1:0]    entries_in_use;
   modport source (output valid, status, found_handle, entries_in_use, input ready);
   modport sink   (input valid, status, found_handle, entries_in_use, output ready);
endinterface

interface ratc_csr_if;
   import ratc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [TIME_W-1:0]     ttl_seconds;
   modport source (output valid, ttl_seconds, input ready);
   modport sink   (input valid, ttl_seconds, output ready);
endinterface

FILE: design/ratc_store.sv
// Entry store: key, expiry and handle memories with one write and one registered read port.
module ratc_store
   import ratc_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int IW    = 5
) (
   input  logic                 clock,
   input  store_wr_type         wr,
   input  logic [IW-1:0]        wr_addr,
   input  logic [KEY_W-1:0]     wr_key,
   input  logic [EXPIRY_W-1:0]  wr_expiry,
   input  logic [HANDLE_W-1:0]  wr_handle,
   input  logic                 rd_en,
   input  logic [IW-1:0]        rd_addr,
   output logic [KEY_W-1:0]     rd_key,
   output logic [EXPIRY_W-1:0]  rd_expiry,
   output logic [HANDLE_W-1:0]  rd_handle
);

   logic [KEY_W-1:0]    key_mem    [DEPTH];
   logic [EXPIRY_W-1:0] expiry_mem [DEPTH];
   logic [HANDLE_W-1:0] handle_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.entry_we) begin
         key_mem[wr_addr]    <= wr_key;
         handle_mem[wr_addr] <= wr_handle;
      end
      if (wr.expiry_we) begin
         expiry_mem[wr_addr] <= wr_expiry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key    <= key_mem[rd_addr];
         rd_expiry <= expiry_mem[rd_addr];
         rd_handle <= handle_mem[rd_addr];
      end
   end

endmodule

FILE: design/reverse_address_ttl_cache.sv
// Top level: reverse address cache with TTL expiry, scanning sequencer and result register.
//
//   channel   dir  handshake                payload
//   req_ch    in   valid/ready              command, addr_high, addr_low, name_handle, now_seconds
//   rsp_ch    out  valid/ready              status, found_handle, entries_in_use
//   csr_ch    in   valid/ready (always rdy) ttl_seconds
//
// Add, search and clean scan the table between acceptance and the result register: one
// memory read per entry through the single store read port, then drain, write-back and
// result states. A skipped clean or an unused command goes straight to the result state.
// The result state waits for a free output register, then an idle state takes the next request.
// Reset clears the valid bits, count, last clean time and TTL (to 60) at once.
// A result waits in the output register; a new transaction is taken once it is loaded.
module reverse_address_ttl_cache
   import ratc_pkg::*;
#(
   parameter int MAX_ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   ratc_req_if.sink    req_ch,
   ratc_rsp_if.source  rsp_ch,
   ratc_csr_if.sink    csr_ch
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ENTRIES);

   seq_state_type state_ff, state_in;

   logic [TIME_W-1:0]      ttl_ff, ttl_in;
   logic [TIME_W-1:0]      last_clean_ff, last_clean_in;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [CW-1:0]          count_ff, count_in;

   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [HANDLE_W-1:0]    handle_ff, handle_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic [EXPIRY_W-1:0]    expiry_ff, expiry_in;

   logic [IW-1:0]          scan_idx_ff, scan_idx_in;
   logic [IW-1:0]          cmp_idx_ff, cmp_idx_in;
   logic                   cmp_live_ff, cmp_live_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic                   hit_ff, hit_in;
   logic [IW-1:0]          hit_idx_ff, hit_idx_in;
   logic [HANDLE_W-1:0]    hit_handle_ff, hit_handle_in;
   logic                   free_ff, free_in;
   logic [IW-1:0]          free_idx_ff, free_idx_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [HANDLE_W-1:0]    res_handle_ff, res_handle_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]    rsp_handle_ff, rsp_handle_in;
   logic [INUSE_W-1:0]     rsp_inuse_ff, rsp_inuse_in;

   logic                   req_accept, clean_due, out_free;
   logic                   seq_ready, seq_issue, seq_write, seq_load;
   logic                   match, stale, insert;
   logic [KEY_W-1:0]       rd_key;
   logic [EXPIRY_W-1:0]    rd_expiry;
   logic [HANDLE_W-1:0]    rd_handle;
   logic [CW+INUSE_W-1:0]  count_ext;
   logic [INUSE_W-1:0]     inuse_sat;
   store_wr_type           store_wr;
   logic [IW-1:0]          store_wr_addr;

   assign req_accept = req_ch.valid && seq_ready;
   assign clean_due  = req_ch.now_seconds > last_clean_ff;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.command == CMD_ADD || req_ch.command == CMD_SEARCH ||
                   (req_ch.command == CMD_CLEAN && clean_due)) begin
                  state_in = SEQ_SCAN;
               end else begin
                  state_in = SEQ_DONE;
               end
            end
         end
         SEQ_SCAN: begin
            if (scan_idx_ff == LAST_IDX) state_in = SEQ_DRAIN;
         end
         SEQ_DRAIN: state_in = SEQ_WRITE;
         SEQ_WRITE: state_in = SEQ_DONE;
         SEQ_DONE: begin
            if (out_free) state_in = SEQ_IDLE;
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      seq_ready = 1'b0;
      seq_issue = 1'b0;
      seq_write = 1'b0;
      seq_load  = 1'b0;
      unique case (state_ff)
         SEQ_IDLE:  seq_ready = 1'b1;
         SEQ_SCAN:  seq_issue = 1'b1;
         SEQ_DRAIN: ;
         SEQ_WRITE: seq_write = 1'b1;
         SEQ_DONE:  seq_load  = out_free;
         default:   ;
      endcase
   end

   assign match  = cmp_live_ff && rd_valid_ff && (rd_key == key_ff);
   assign stale  = cmp_live_ff && rd_valid_ff && (cmd_ff == CMD_CLEAN) &&
                   (rd_expiry < {1'b0, now_ff});
   assign insert = seq_write && (cmd_ff == CMD_ADD) && !hit_ff && free_ff &&
                   (count_ff < FULL_CNT);

   assign store_wr.entry_we  = insert;
   assign store_wr.expiry_we = insert || (seq_write && (cmd_ff == CMD_ADD) && hit_ff);
   assign store_wr_addr      = hit_ff ? hit_idx_ff : free_idx_ff;

   assign count_ext = {{INUSE_W{1'b0}}, count_ff};
   assign inuse_sat = (count_ext > (CW+INUSE_W)'(63)) ? 6'd63 : count_ext[INUSE_W-1:0];

   always_comb begin
      ttl_in        = ttl_ff;
      last_clean_in = last_clean_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      handle_in     = handle_ff;
      now_in        = now_ff;
      expiry_in     = expiry_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_idx_in    = scan_idx_ff;
      cmp_live_in   = seq_issue;
      rd_valid_in   = valid_ff[scan_idx_ff];
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_handle_in = hit_handle_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_inuse_in  = rsp_inuse_ff;

      if (csr_ch.valid) ttl_in = csr_ch.ttl_seconds;

      if (req_accept) begin
         cmd_in        = req_ch.command;
         key_in        = {req_ch.addr_high, req_ch.addr_low};
         handle_in     = req_ch.name_handle;
         now_in        = req_ch.now_seconds;
         expiry_in     = {1'b0, req_ch.now_seconds} + {1'b0, ttl_ff};
         scan_idx_in   = '0;
         hit_in        = 1'b0;
         free_in       = 1'b0;
         res_handle_in = '0;
         res_status_in = (req_ch.command == CMD_CLEAN) ? ST_CLEAN_SKIP : ST_MISS;
      end

      if (seq_issue && scan_idx_ff != LAST_IDX) scan_idx_in = scan_idx_ff + 1'b1;

      if (match && !hit_ff) begin
         hit_in        = 1'b1;
         hit_idx_in    = cmp_idx_ff;
         hit_handle_in = rd_handle;
      end
      if (cmp_live_ff && !rd_valid_ff && !free_ff) begin
         free_in     = 1'b1;
         free_idx_in = cmp_idx_ff;
      end
      if (stale) begin
         valid_in[cmp_idx_ff] = 1'b0;
         if (count_ff != '0) count_in = count_ff - 1'b1;
      end

      if (seq_write) begin
         case (cmd_ff)
            CMD_ADD: begin
               if (hit_ff)      res_status_in = ST_REFRESHED;
               else if (insert) res_status_in = ST_INSERTED;
               else             res_status_in = ST_DROPPED;
            end
            CMD_SEARCH: begin
               res_status_in = hit_ff ? ST_HIT : ST_MISS;
               res_handle_in = hit_ff ? hit_handle_ff : '0;
            end
            CMD_CLEAN: begin
               res_status_in = ST_CLEANED;
               last_clean_in = now_ff;
            end
            default: res_status_in = ST_MISS;
         endcase
      end
      if (insert) begin
         valid_in[free_idx_ff] = 1'b1;
         count_in              = count_ff + 1'b1;
      end

      if (seq_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_handle_in = res_handle_ff;
         rsp_inuse_in  = inuse_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         ttl_ff        <= TTL_RESET;
         last_clean_ff <= '0;
         valid_ff      <= '0;
         count_ff      <= '0;
         cmp_live_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ttl_ff        <= ttl_in;
         last_clean_ff <= last_clean_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         cmp_live_ff   <= cmp_live_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      handle_ff     <= handle_in;
      now_ff        <= now_in;
      expiry_ff     <= expiry_in;
      scan_idx_ff   <= scan_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      rd_valid_ff   <= rd_valid_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_handle_ff <= hit_handle_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_inuse_ff  <= rsp_inuse_in;
   end

   ratc_store #(
      .DEPTH (MAX_ENTRIES),
      .IW    (IW)
   ) u_store (
      .clock     (clock),
      .wr        (store_wr),
      .wr_addr   (store_wr_addr),
      .wr_key    (key_ff),
      .wr_expiry (expiry_ff),
      .wr_handle (handle_ff),
      .rd_en     (seq_issue),
      .rd_addr   (scan_idx_ff),
      .rd_key    (rd_key),
      .rd_expiry (rd_expiry),
      .rd_handle (rd_handle)
   );

   assign req_ch.ready          = seq_ready;
   assign csr_ch.ready          = 1'b1;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.found_handle   = rsp_handle_ff;
   assign rsp_ch.entries_in_use = rsp_inuse_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above table size");

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("entry count differs from valid marks");

   a_skip_keeps_time: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_ch.command == CMD_CLEAN && !clean_due) |=> $stable(last_clean_ff))
      else $error("skipped clean changed last clean time");

   a_scan_feeds_compare: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_SCAN) |=> cmp_live_ff)
      else $error("scan read not followed by compare");

endmodule

FILE: tb/ttl_cache_checker.sv
// Checker for the reverse address TTL cache: tracks the table, predicts and compares responses.
module ttl_cache_checker #(
   parameter int SLOTS = 32
) (
   input  logic clock,
   input  logic reset,
   ratc_req_if  req_ch,
   ratc_rsp_if  rsp_ch,
   ratc_csr_if  csr_ch,
   output int   mismatch_count,
   output int   awaiting
);
   timeunit 1ns;
   timeprecision 1ps;
   import ratc_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle;
      logic [INUSE_W-1:0]  in_use;
   } cache_reply_type;

   cache_reply_type       replies_due[$];
   logic                  slot_live   [SLOTS];
   logic [KEY_W-1:0]      slot_key    [SLOTS];
   logic [EXPIRY_W-1:0]   slot_expiry [SLOTS];
   logic [HANDLE_W-1:0]   slot_handle [SLOTS];
   int                    live_count;
   logic [TIME_W-1:0]     last_sweep;
   logic [TIME_W-1:0]     ttl_now;
   int                    fails = 0;

   function automatic cache_reply_type apply_command(input logic [CMD_W-1:0]    cmd,
                                                     input logic [KEY_W-1:0]    key,
                                                     input logic [HANDLE_W-1:0] handle,
                                                     input logic [TIME_W-1:0]   now);
      cache_reply_type     r;
      int                  hit;
      logic [EXPIRY_W-1:0] expiry;
      r.status = ST_MISS;
      r.handle = '0;
      hit = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (hit < 0 && slot_live[i] && slot_key[i] == key) hit = i;
      end
      // 33-bit expiry, never wraps
      expiry = {1'b0, now} + {1'b0, ttl_now};
      case (cmd)
         CMD_ADD: begin
            if (hit >= 0) begin
               slot_expiry[hit] = expiry;
               r.status = ST_REFRESHED;
            end else begin
               r.status = ST_DROPPED;
               if (live_count < SLOTS) begin
                  for (int i = 0; i < SLOTS; i++) begin
                     if (r.status == ST_DROPPED && !slot_live[i]) begin
                        slot_live[i]   = 1'b1;
                        slot_key[i]    = key;
                        slot_expiry[i] = expiry;
                        slot_handle[i] = handle;
                        live_count++;
                        r.status = ST_INSERTED;
                     end
                  end
               end
            end
         end
         CMD_SEARCH: begin
            if (hit >= 0) begin
               r.status = ST_HIT;
               r.handle = slot_handle[hit];
            end
         end
         CMD_CLEAN: begin
            if (now > last_sweep) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_live[i] && slot_expiry[i] < {1'b0, now}) begin
                     slot_live[i] = 1'b0;
                     if (live_count > 0) live_count--;
                  end
               end
               last_sweep = now;
               r.status = ST_CLEANED;
            end else begin
               r.status = ST_CLEAN_SKIP;
            end
         end
         default: ;
      endcase
      r.in_use = (live_count > 63) ? 6'd63 : live_count[INUSE_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      cache_reply_type got;
      cache_reply_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
         live_count = 0;
         last_sweep = '0;
         ttl_now    = TTL_RESET;
         replies_due.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) ttl_now = csr_ch.ttl_seconds;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status = rsp_ch.status;
            got.handle = rsp_ch.found_handle;
            got.in_use = rsp_ch.entries_in_use;
            if (replies_due.size() == 0) begin
               fails++;
               if (fails <= REPORT_LIMIT)
                  $display({"ttl_cache_checker: unexpected transaction ",
                            "status=%0d handle=%h in_use=%0d"},
                           got.status, got.handle, got.in_use);
            end else begin
               want = replies_due.pop_front();
               if (got !== want) begin
                  fails++;
                  if (fails <= REPORT_LIMIT)
                     $display({"ttl_cache_checker: expected status=%0d handle=%h in_use=%0d, ",
                               "got status=%0d handle=%h in_use=%0d"},
                              want.status, want.handle, want.in_use,
                              got.status, got.handle, got.in_use);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            replies_due.push_back(apply_command(req_ch.command,
                                                {req_ch.addr_high, req_ch.addr_low},
                                                req_ch.name_handle, req_ch.now_seconds));
      end
      awaiting       <= replies_due.size();
      mismatch_count <= fails;
   end

endmodule

FILE: tb/tb.sv
// Testbench top for the reverse address TTL cache: stimulus, flow control and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ratc_pkg::*;

   localparam int SLOTS          = 32;
   localparam int POOL           = 40;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 75;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE         = SLOTS + 8;
   localparam logic [CMD_W-1:0]  CMD_SPARE = 2'd3;
   localparam logic [TIME_W-1:0] TIME_MAX  = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ratc_req_if req_ch ();
   ratc_rsp_if rsp_ch ();
   ratc_csr_if csr_ch ();

   int                send_gap_pct   = 0;
   int                recv_stall_pct = 0;
   int                errors;
   int                pending;
   int                idle_cycles    = 0;
   logic [TIME_W-1:0] wall_clock;
   logic [KEY_W-1:0]  key_pool [POOL];
   logic [TIME_W-1:0] ttl_plan [PHASES] = '{32'd0, 32'd25, 32'd120, 32'd7,
                                            32'd300, 32'd1, 32'd0, TIME_MAX};

   reverse_address_ttl_cache #(.MAX_ENTRIES(SLOTS)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   ttl_cache_checker #(.SLOTS(SLOTS)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_count (errors),
      .awaiting       (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(1, 100) > recv_stall_pct);
   end

   // no-progress watchdog
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic issue(input logic [CMD_W-1:0]    cmd,
                        input logic [KEY_W-1:0]    key,
                        input logic [HANDLE_W-1:0] handle,
                        input logic [TIME_W-1:0]   now);
      if ($urandom_range(1, 100) <= send_gap_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(1, 100) <= send_gap_pct);
      end
      req_ch.valid       <= 1'b1;
      req_ch.command     <= cmd;
      req_ch.addr_high   <= key[KEY_W-1:HALF_W];
      req_ch.addr_low    <= key[HALF_W-1:0];
      req_ch.name_handle <= handle;
      req_ch.now_seconds <= now;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_ttl(input logic [TIME_W-1:0] ttl);
      drain();
      csr_ch.valid       <= 1'b1;
      csr_ch.ttl_seconds <= ttl;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic random_item();
      int                  pick;
      logic [CMD_W-1:0]    cmd;
      logic [KEY_W-1:0]    key;
      logic [TIME_W-1:0]   now;
      logic [HANDLE_W-1:0] handle;
      wall_clock = wall_clock + $urandom_range(0, 6);
      pick   = $urandom_range(1, 100);
      handle = $urandom;
      if ($urandom_range(1, 100) <= 85) key = key_pool[$urandom_range(0, POOL - 1)];
      else key = {$urandom, $urandom, $urandom, $urandom};
      if (pick <= 45) begin
         cmd = CMD_ADD;
         now = ($urandom_range(1, 10) == 1) ? $urandom_range(0, wall_clock) : wall_clock;
      end else if (pick <= 80) begin
         cmd = CMD_SEARCH;
         now = $urandom;
      end else if (pick <= 95) begin
         // some cleans at or before the last sweep time
         cmd = CMD_CLEAN;
         now = ($urandom_range(1, 5) == 1) ? wall_clock - $urandom_range(0, 3) : wall_clock;
      end else begin
         cmd = CMD_SPARE;
         now = $urandom;
      end
      issue(cmd, key, handle, now);
   endtask

   initial begin
      req_ch.valid       <= 1'b0;
      req_ch.command     <= CMD_ADD;
      req_ch.addr_high   <= '0;
      req_ch.addr_low    <= '0;
      req_ch.name_handle <= '0;
      req_ch.now_seconds <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.ttl_seconds <= '0;
      wall_clock = 32'd100;
      for (int i = 0; i < POOL; i++) begin
         key_pool[i] = {$urandom, $urandom, $urandom, $urandom};
         // near misses: one half shared with the previous key
         if (i % 4 == 1) key_pool[i][KEY_W-1:HALF_W] = key_pool[i-1][KEY_W-1:HALF_W];
         if (i % 4 == 2) key_pool[i][HALF_W-1:0] = key_pool[i-1][HALF_W-1:0];
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      issue(CMD_CLEAN, '0, '0, '0);
      issue(CMD_SEARCH, '0, '0, '0);
      issue(CMD_ADD, '0, '0, '0);
      issue(CMD_ADD, '1, '1, TIME_MAX);
      issue(CMD_ADD, '0, 32'h1234_5678, 32'd10);
      issue(CMD_SEARCH, '1, '0, '0);
      issue(CMD_SEARCH, '0, '1, TIME_MAX);
      issue(CMD_SEARCH, {64'd0, 64'd1}, '0, '0);
      issue(CMD_SEARCH, {64'd1, 64'd0}, '0, '0);
      issue(CMD_SPARE, '1, '1, '1);
      issue(CMD_CLEAN, '0, '0, 32'd71);
      issue(CMD_CLEAN, '0, '0, 32'd71);
      issue(CMD_CLEAN, '0, '0, 32'd50);
      issue(CMD_SEARCH, '0, '0, '0);
      issue(CMD_CLEAN, '1, '1, 32'd72);

      for (int p = 0; p < PHASES; p++) begin
         write_ttl((p == 6) ? 32'($urandom) : ttl_plan[p]);
         case (p % 4)
            0: begin
               send_gap_pct = 0;
               recv_stall_pct <= 0;
            end
            1: begin
               send_gap_pct = 71;
               recv_stall_pct <= 0;
            end
            2: begin
               send_gap_pct = 0;
               recv_stall_pct <= 71;
            end
            default: begin
               send_gap_pct = 13;
               recv_stall_pct <= 13;
            end
         endcase
         repeat (PHASE_ITEMS) random_item();
      end

      // sweep at the top of the time range; long-lived entries survive it
      issue(CMD_CLEAN, '0, '0, TIME_MAX);
      issue(CMD_CLEAN, '0, '0, TIME_MAX);
      issue(CMD_SEARCH, key_pool[0], '0, TIME_MAX);

      drain();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
